/* sv/rhht_pkg.sv */
// shared constants, codes and control/status structs of the robin hood hash table
// no dependencies
package rhht_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 64;
	localparam int DIST_W    = 8;
	localparam int DIST_MAX  = 255;
	localparam int FILL_W    = 9;
	localparam int ENTRY_W   = DIST_W + VAL_W + 2 * KEY_W;
	localparam logic [FILL_W-1:0] FILL_RESET = 9'd192;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic refuse;
		logic home_start;
		logic step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic refuse;
		logic home_done;
		logic probe_end;
	} stat_t;

endpackage

/* sv/rhht_ram.sv */
// generic single write port memory with registered read
// no dependencies
module rhht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/rhht_mod.sv */
// home slot unit: hash modulo slot count, a mask for a power of two,
// otherwise a byte fold and a reciprocal multiply, each step registered; uses rhht_pkg
module rhht_mod
	import rhht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [KEY_W-1:0]         hash,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] home
);

	localparam int AW   = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam int NB   = KEY_W / 8;
	localparam int TW   = AW + 11;
	localparam int RCW  = AW + 12;
	localparam int PW   = TW + RCW;
	localparam int SH   = TW + AW;
	localparam int QW   = 12;
	// rounded-up reciprocal, exact quotient for any folded sum below 2**TW
	localparam logic [RCW-1:0] RECIP =
		RCW'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

	// weight of hash byte pos: 2**(8*pos) modulo the slot count
	function automatic int byte_weight(int pos);
		int w;
		w = 1;
		for (int k = 0; k < 8 * pos; k++) begin
			w = (w * 2) % SLOTS;
		end
		return w;
	endfunction

	logic          v1_q;
	logic          v2_q;
	logic          done_q;
	logic [TW-1:0] part [NB];
	logic [TW-1:0] fold_sum;
	logic [TW-1:0] t_q;
	logic [PW-1:0] prod;
	logic [QW-1:0] q_q;
	logic [TW-1:0] rem_full;
	logic [AW-1:0] rem_q;

	for (genvar g = 0; g < NB; g++) begin : g_fold
		localparam logic [TW-1:0] WT = TW'(byte_weight(g));
		assign part[g] = TW'(hash[8*g +: 8]) * WT;
	end

	always_comb begin
		fold_sum = '0;
		for (int i = 0; i < NB; i++) begin
			fold_sum = fold_sum + part[i];
		end
	end

	assign prod     = PW'(t_q) * PW'(RECIP);
	assign rem_full = t_q - TW'(q_q) * TW'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_q   <= start && !POW2;
			v2_q   <= v1_q;
			done_q <= (start && POW2) || v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q   <= fold_sum;
			rem_q <= hash[AW-1:0];
		end
		if (v1_q) begin
			q_q <= QW'(prod >> SH);
		end
		if (v2_q) begin
			rem_q <= rem_full[AW-1:0];
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

/* sv/rhht_datapath.sv */
// datapath: slot memories, carried entry, probe index, counters and result registers
// uses rhht_pkg, rhht_ram and rhht_mod
module rhht_datapath
	import rhht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output stat_t                     stat,
	input  logic [3*KEY_W-1:0]        s_tdata,
	input  logic                      s_tuser,
	input  logic                      cfg_valid,
	input  logic [FILL_W-1:0]         cfg_data,
	output logic [VAL_W-1:0]          m_tdata,
	output logic [1:0]                m_tuser
);

	localparam int AW = $clog2(SLOTS);
	localparam int NW = AW + 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int DW = $clog2(SLOTS) + 2;

	logic [FILL_W-1:0] fill_limit_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     clr_idx_q;
	logic [AW-1:0]     idx_q;
	logic [NW-1:0]     n_q;
	logic [DW-1:0]     dist_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  hash_q;
	logic [VAL_W-1:0]  val_q;
	logic              res_found_q;
	logic [VAL_W-1:0]  res_val_q;
	logic              res_status_q;

	logic              home_done;
	logic [AW-1:0]     home;
	logic              rd_used;
	logic [ENTRY_W-1:0] rd_ent;
	logic [KEY_W-1:0]  rd_key;
	logic [KEY_W-1:0]  rd_hash;
	logic [VAL_W-1:0]  rd_val;
	logic [DIST_W-1:0] rd_dist;
	logic [DIST_W-1:0] dist_clamped;
	logic              last_probe;
	logic              hit;
	logic              free;
	logic              keq;
	logic              swap;
	logic              probe_end;
	logic              full;
	logic              ent_we;
	logic [ENTRY_W-1:0] ent_wdata;
	logic              used_we;
	logic              used_wdata;
	logic [AW-1:0]     used_waddr;
	logic [AW-1:0]     idx_next;

	rhht_mod #(.SLOTS(SLOTS)) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.home_start),
		.hash  (hash_q),
		.done  (home_done),
		.home  (home)
	);

	rhht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
		.clk  (clk),
		.we   (used_we),
		.waddr(used_waddr),
		.wdata(used_wdata),
		.raddr(idx_q),
		.rdata(rd_used)
	);

	rhht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_entry (
		.clk  (clk),
		.we   (ent_we),
		.waddr(idx_q),
		.wdata(ent_wdata),
		.raddr(idx_q),
		.rdata(rd_ent)
	);

	// entry layout from the lowest bit: key, hash, value, distance
	assign rd_key  = rd_ent[KEY_W-1:0];
	assign rd_hash = rd_ent[2*KEY_W-1:KEY_W];
	assign rd_val  = rd_ent[2*KEY_W+VAL_W-1:2*KEY_W];
	assign rd_dist = rd_ent[ENTRY_W-1:2*KEY_W+VAL_W];

	assign dist_clamped = (32'(dist_q) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(dist_q);
	assign last_probe   = n_q == NW'(SLOTS - 1);
	assign hit   = rd_used && rd_hash == hash_q && rd_key == key_q;
	assign free  = !rd_used;
	assign keq   = rd_used && rd_key == key_q;
	assign swap  = rd_used && !keq && (32'(rd_dist) < 32'(dist_q));
	assign probe_end = (op_q == OP_INSERT) ? (free || keq || last_probe)
	                                       : (free || hit || last_probe);
	assign full  = (32'(count_q) >= 32'(fill_limit_q)) || (32'(count_q) >= 32'(SLOTS));
	assign idx_next = (idx_q == AW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

	assign ent_we    = cmd.step && op_q == OP_INSERT && (free || keq || swap);
	assign ent_wdata = keq ? {dist_clamped, val_q, rd_hash, rd_key}
	                       : {dist_clamped, val_q, hash_q, key_q};
	assign used_we    = cmd.clr || (cmd.step && op_q == OP_INSERT && free);
	assign used_wdata = !cmd.clr;
	assign used_waddr = cmd.clr ? clr_idx_q : idx_q;

	assign stat.clr_last  = clr_idx_q == AW'(SLOTS - 1);
	assign stat.refuse    = op_q == OP_INSERT && full;
	assign stat.home_done = home_done;
	assign stat.probe_end = probe_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_limit_q <= FILL_RESET;
			count_q      <= '0;
			clr_idx_q    <= '0;
		end else begin
			if (cfg_valid) begin
				fill_limit_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.step && op_q == OP_INSERT && free) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[KEY_W-1:0];
			hash_q <= s_tdata[2*KEY_W-1:KEY_W];
			val_q  <= s_tdata[3*KEY_W-1:2*KEY_W];
		end
		if (home_done) begin
			idx_q  <= home;
			n_q    <= '0;
			dist_q <= '0;
		end
		if (cmd.refuse) begin
			res_found_q  <= 1'b0;
			res_val_q    <= '0;
			res_status_q <= 1'b1;
		end
		if (cmd.step) begin
			idx_q <= idx_next;
			n_q   <= n_q + 1'b1;
			if (op_q == OP_INSERT && swap) begin
				// carry the evicted resident onward
				key_q  <= rd_key;
				hash_q <= rd_hash;
				val_q  <= rd_val;
				dist_q <= DW'(32'(rd_dist) + 1);
			end else begin
				dist_q <= dist_q + 1'b1;
			end
			if (probe_end) begin
				res_found_q  <= (op_q == OP_INSERT) ? (free || keq) : hit;
				res_val_q    <= (op_q == OP_LOOKUP && hit) ? rd_val : '0;
				res_status_q <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			m_tdata <= res_val_q;
			m_tuser <= {res_status_q, res_found_q};
		end
	end

endmodule

/* sv/rhht_ctrl.sv */
// controller: clearing pass, item sequencing and output register handshake
// uses rhht_pkg
module rhht_ctrl
	import rhht_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	output cmd_t  cmd,
	input  stat_t stat
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_HOME  = 3'd3;
	localparam logic [2:0] ST_ISSUE = 3'd4;
	localparam logic [2:0] ST_EVAL  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (stat.refuse) begin
					cmd.refuse = 1'b1;
					state_d    = ST_DONE;
				end else begin
					cmd.home_start = 1'b1;
					state_d        = ST_HOME;
				end
			end
			ST_HOME: begin
				if (stat.home_done) state_d = ST_ISSUE;
			end
			// slot read in flight
			ST_ISSUE: state_d = ST_EVAL;
			ST_EVAL: begin
				cmd.step = 1'b1;
				state_d  = stat.probe_end ? ST_DONE : ST_ISSUE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* sv/robin_hood_hash_table.sv */
// channel   | signals                         | contents
// s (in)    | s_tvalid s_tready s_tdata s_tuser | key, hash, value; operation
// m (out)   | m_tvalid m_tready m_tdata m_tuser | read_value; found, status
// cfg (in)  | cfg_valid cfg_ready cfg_data    | fill_limit, always ready
// an item passes the states start and home, then an issue and an eval state for each slot
// probed, because of the registered read of the slot memories; home waits for the remainder
// unit, a mask for a power-of-two slot count, else the fold and reciprocal path. a refused
// insert goes from start to done. after reset a clearing pass over every slot empties the
// occupancy memory; no item is taken meanwhile. the output register holds a result while
// the next item is taken in; the next result waits until that transfer happens.
module robin_hood_hash_table
	import rhht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [191:0]      s_tdata,  // item_key, item_hash, item_value
	input  logic              s_tuser,  // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,  // read_value
	output logic [1:0]        m_tuser,  // found, status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FILL_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	rhht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	rhht_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_refuse_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
		else $error("refused insert reported as stored");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.load, cmd.refuse, cmd.home_start, cmd.step, cmd.out_load}))
		else $error("controller issued more than one command");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_tready)
		else $error("item taken while the previous one is in progress");

endmodule

/* sim/tb_robin_hood_hash_table.sv */
// self-checking bench for the robin hood hash table: directed rows, then random traffic
// mirrored slot for slot by a behavioural table. depends on rhht_pkg and robin_hood_hash_table
module tb_robin_hood_hash_table;
	timeunit 1ns;
	timeprecision 1ps;
	import rhht_pkg::*;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;
	localparam int   NSLOT   = SLOTS_DEF;
	localparam int   POOL    = 320;

	typedef struct packed {
		logic              found;
		logic [VAL_W-1:0]  value;
		logic              status;
	} outcome_t;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [63:0]       hash;
		logic [VAL_W-1:0]  value;
		logic              typed;
		outcome_t          want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [191:0]      s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [63:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [FILL_W-1:0] cfg_data;

	robin_hood_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// behavioural copy of the table
	logic              tbl_used [NSLOT];
	logic [KEY_W-1:0]  tbl_key  [NSLOT];
	logic [63:0]       tbl_hash [NSLOT];
	logic [VAL_W-1:0]  tbl_val  [NSLOT];
	logic [DIST_W-1:0] tbl_dist [NSLOT];
	int                tbl_count;
	int                fill_limit;

	outcome_t          pending_q[$];
	int                failures;
	int                n_hits, n_stored, n_refused, n_items;
	logic              hold_req;
	logic [KEY_W-1:0]  pool_key [POOL];
	logic [63:0]       pool_hash[POOL];

	function automatic logic [DIST_W-1:0] sat_dist(int d);
		return (d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(d);
	endfunction

	function automatic outcome_t table_apply(logic op, logic [KEY_W-1:0] key,
			logic [63:0] hash, logic [VAL_W-1:0] value);
		outcome_t r;
		int idx;
		int probe_dist;
		logic [KEY_W-1:0] tk;
		logic [63:0] th;
		logic [VAL_W-1:0] tv;
		int td;
		r = '0;
		idx = int'(hash % 64'(NSLOT));
		probe_dist = 0;
		if (op == OP_LOOKUP) begin
			for (int n = 0; n < NSLOT; n++) begin
				if (!tbl_used[idx]) break;
				if (tbl_hash[idx] == hash && tbl_key[idx] == key) begin
					r.found = 1'b1;
					r.value = tbl_val[idx];
					break;
				end
				idx = (idx + 1) % NSLOT;
			end
			return r;
		end
		if (tbl_count >= fill_limit || tbl_count >= NSLOT) begin
			r.status = ST_FULL;
			return r;
		end
		for (int n = 0; n < NSLOT; n++) begin
			if (!tbl_used[idx]) begin
				tbl_used[idx] = 1'b1;
				tbl_key[idx] = key;
				tbl_hash[idx] = hash;
				tbl_val[idx] = value;
				tbl_dist[idx] = sat_dist(probe_dist);
				tbl_count++;
				r.found = 1'b1;
				return r;
			end
			if (tbl_key[idx] == key) begin
				tbl_val[idx] = value;
				tbl_dist[idx] = sat_dist(probe_dist);
				r.found = 1'b1;
				return r;
			end
			if (int'(tbl_dist[idx]) < probe_dist) begin
				// resident is closer to home: it gives up the slot and travels on
				tk = tbl_key[idx];
				th = tbl_hash[idx];
				tv = tbl_val[idx];
				td = tbl_dist[idx];
				tbl_key[idx] = key;
				tbl_hash[idx] = hash;
				tbl_val[idx] = value;
				tbl_dist[idx] = sat_dist(probe_dist);
				key = tk;
				hash = th;
				value = tv;
				probe_dist = td;
			end
			idx = (idx + 1) % NSLOT;
			probe_dist++;
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

	// result checker
	always @(posedge clk) begin
		outcome_t want;
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result found=%0b value=%h status=%0b",
					$time, m_tuser[0], m_tdata, m_tuser[1]);
				failures++;
			end else begin
				want = pending_q.pop_front();
				if (m_tuser[0] !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser[0]);
					failures++;
				end
				if (m_tdata !== want.value) begin
					$display("%0t: read_value expected %h actual %h", $time, want.value, m_tdata);
					failures++;
				end
				if (m_tuser[1] !== want.status) begin
					$display("%0t: status expected %0b actual %0b", $time, want.status, m_tuser[1]);
					failures++;
				end
			end
		end
	end

	// receiver: random stall per transfer, one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (hold_req) begin
				hold_req = 1'b0;
				gap = 400;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= FILL_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_limit = v;
	endtask

	task automatic send(row_t it, bit burst);
		outcome_t got;
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {it.value, it.hash, it.key};
		do @(posedge clk); while (!s_tready);
		got = table_apply(it.op, it.key, it.hash, it.value);
		pending_q.push_back(it.typed ? it.want : got);
		n_items++;
		if (got.found && it.op == OP_LOOKUP) n_hits++;
		if (got.found && it.op == OP_INSERT) n_stored++;
		if (got.status == ST_FULL) n_refused++;
	endtask

	function automatic row_t mk(logic op, logic [63:0] key, logic [63:0] hash,
			logic [63:0] value);
		row_t r;
		r = '0;
		r.op = op;
		r.key = key;
		r.hash = hash;
		r.value = value;
		return r;
	endfunction

	function automatic row_t mk_typed(logic op, logic [63:0] key, logic [63:0] hash,
			logic [63:0] value, logic found, logic [63:0] rv, logic status);
		row_t r;
		r = mk(op, key, hash, value);
		r.typed = 1'b1;
		r.want = '{found: found, value: rv, status: status};
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic row_t random_item();
		row_t r;
		int p;
		p = $urandom_range(0, POOL - 1);
		r = mk(1'($urandom_range(0, 1)), pool_key[p], pool_hash[p], rnd64());
		case ($urandom_range(0, 19))
			0: r.key = rnd64();
			1, 2, 3: r.hash = rnd64();
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		row_t plan[$];
		row_t it;
		logic [63:0] ones;
		ones = '1;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOOKUP;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
		failures = 0;
		n_hits = 0;
		n_stored = 0;
		n_refused = 0;
		n_items = 0;
		tbl_count = 0;
		fill_limit = FILL_RESET;
		for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
		for (int i = 0; i < POOL; i++) begin
			pool_key[i] = rnd64();
			pool_hash[i] = rnd64();
			// a quarter crowd into a few home slots for long probe runs
			if (i % 4 == 0) pool_hash[i][7:0] = 8'($urandom_range(0, 15));
		end

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		plan.push_back(mk_typed(OP_LOOKUP, 0, 0, 0, 0, 0, ST_OK));
		plan.push_back(mk_typed(OP_LOOKUP, ones, ones, ones, 0, 0, ST_OK));
		plan.push_back(mk_typed(OP_INSERT, 0, 0, ones, 1, 0, ST_OK));
		plan.push_back(mk_typed(OP_LOOKUP, 0, 0, 0, 1, ones, ST_OK));
		plan.push_back(mk_typed(OP_INSERT, ones, ones, 0, 1, 0, ST_OK));
		plan.push_back(mk_typed(OP_LOOKUP, ones, ones, ones, 1, 0, ST_OK));
		// same key, other hash with the same home: updated on key alone
		plan.push_back(mk(OP_INSERT, 0, 64'h100, 64'h1234));
		plan.push_back(mk(OP_LOOKUP, 0, 0, 0));
		plan.push_back(mk(OP_LOOKUP, 0, 64'h100, 0));
		// a cluster at slot 3 and a late arrival at slot 4 to force swaps
		for (int k = 0; k < 4; k++) plan.push_back(mk(OP_INSERT, 10 + k, 3, 100 + k));
		plan.push_back(mk(OP_INSERT, 20, 4, 200));
		plan.push_back(mk(OP_INSERT, 21, 3, 201));
		plan.push_back(mk(OP_INSERT, 22, 5, 202));
		for (int k = 0; k < 4; k++) plan.push_back(mk(OP_LOOKUP, 10 + k, 3, 0));
		plan.push_back(mk(OP_LOOKUP, 20, 4, 0));
		plan.push_back(mk(OP_LOOKUP, 21, 3, 0));
		plan.push_back(mk(OP_LOOKUP, 22, 5, 0));
		plan.push_back(mk(OP_LOOKUP, 99, 3, 0));
		foreach (plan[i]) send(plan[i], 1'b0);

		// smallest limit: table already holds more, so even updates are refused
		write_limit(1);
		send(mk_typed(OP_INSERT, 0, 0, 5, 0, 0, ST_FULL), 1'b0);
		send(mk_typed(OP_INSERT, 77, 9, 5, 0, 0, ST_FULL), 1'b0);
		send(mk(OP_LOOKUP, 0, 0, 0), 1'b0);

		write_limit(192);
		for (int i = 0; i < 1450; i++) begin
			if (i == 300) hold_req = 1'b1;
			if (i == 700) drain();
			it = random_item();
			send(it, (i >= 300 && i < 340) || (i >= 900 && i < 960));
		end

		write_limit(64);
		for (int i = 0; i < 60; i++) send(random_item(), 1'b0);

		// largest limit: fill every slot with a tight cluster, then probe a full table
		write_limit(256);
		while (tbl_count < NSLOT) begin
			it = mk(OP_INSERT, rnd64(), rnd64(), rnd64());
			it.hash[7:0] = 8'($urandom_range(200, 203));
			send(it, 1'b0);
		end
		for (int i = 0; i < 20; i++) send(mk(OP_LOOKUP, rnd64(), rnd64(), 0), 1'b0);
		for (int i = 0; i < 120; i++) send(random_item(), 1'b0);

		s_tvalid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		$display("%0d items: %0d lookup hits, %0d inserts stored, %0d refused",
			n_items, n_hits, n_stored, n_refused);
		$display("fill limits 1, 64, 192 and 256 exercised, table ended with %0d entries",
			tbl_count);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/rhht_pkg.sv
sv/rhht_ram.sv
sv/rhht_mod.sv
sv/rhht_datapath.sv
sv/rhht_ctrl.sv
sv/robin_hood_hash_table.sv
sim/tb_robin_hood_hash_table.sv
